>>> design/cbfm_pkg.sv
package cbfm_pkg;

    localparam int NUM_FRAMES = 16;
    localparam int PIN_BITS   = 8;
    localparam int FRAME_W    = $clog2(NUM_FRAMES);
    localparam int STEP_W     = $clog2(2 * NUM_FRAMES + 1);
    localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

    typedef enum logic [1:0] {
        KIND_READ    = 2'd0,
        KIND_ALLOC   = 2'd1,
        KIND_UNPIN   = 2'd2,
        KIND_DISPOSE = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_HIT        = 3'd0,
        ST_ASSIGNED   = 3'd1,
        ST_ALL_PINNED = 3'd2,
        ST_NOT_FOUND  = 3'd3,
        ST_NOT_PINNED = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  file_id;
        logic [15:0] page_no;
        logic        dirty_mark;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  frame;
        logic        need_read;
        logic        write_back;
        logic [7:0]  victim_file;
        logic [15:0] victim_page;
    } rsp_t;

    typedef struct packed {
        logic                valid;
        logic                referenced;
        logic                dirty;
        logic [PIN_BITS-1:0] pins;
        logic [7:0]          tag_file;
        logic [15:0]         tag_page;
    } desc_t;

endpackage

>>> design/clock_buffer_frame_manager.sv
// a request first scans all frames in use (n = frames in use); a hit then updates that frame,
// an unpin or dispose that finds nothing answers not found, and a read or alloc that misses
// sweeps the clock hand, reading and then checking each frame it passes, up to 2n frames
// one request at a time: a new request is accepted only in the idle state
// reset: synchronous, active low; valid bits clear at once, hand = frames in use - 1
module clock_buffer_frame_manager (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cbfm_pkg::req_t      s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cbfm_pkg::rsp_t      m_data,
    input  logic                cfg_we,
    input  logic [4:0]          cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOOK  = 6'b000010,
        S_DECIDE= 6'b000100,
        S_SWEEP = 6'b001000,
        S_SWCHK = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    localparam int FW = cbfm_pkg::FRAME_W;

    state_t state_reg, state_next;

    // descriptor memory; valid bits live in flops so reset clears them
    cbfm_pkg::desc_t mem [cbfm_pkg::NUM_FRAMES];
    logic [cbfm_pkg::NUM_FRAMES-1:0] vbit_reg;
    cbfm_pkg::desc_t rd_reg;
    logic [FW-1:0] rd_addr_reg;
    logic          mem_we;
    logic [FW-1:0] mem_wa;
    cbfm_pkg::desc_t mem_wd;
    logic          rd_en;
    logic [FW-1:0] rd_addr;

    logic [4:0]      fiu_reg;
    logic [FW:0]     n_act;
    logic [FW-1:0]   hand_reg, hand_next;
    logic [FW:0]     idx_reg, idx_next;
    logic [cbfm_pkg::STEP_W-1:0] step_reg, step_next;
    cbfm_pkg::req_t  req_reg;
    logic            hit_reg, hit_next;
    logic [FW-1:0]   hit_frame_reg, hit_frame_next;
    cbfm_pkg::rsp_t  rsp_reg, rsp_next;
    logic            chk_reg, chk_next;
    cbfm_pkg::desc_t cur;

    always_comb begin
        if (fiu_reg == 5'd0) n_act = (FW+1)'(1);
        else if (32'(fiu_reg) > cbfm_pkg::NUM_FRAMES) n_act = (FW+1)'(cbfm_pkg::NUM_FRAMES);
        else n_act = (FW+1)'(fiu_reg);
    end

    always_comb begin
        cur = rd_reg;
        cur.valid = vbit_reg[rd_addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        if (rd_en) begin
            rd_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_data  = rsp_reg;

    always_comb begin
        state_next = state_reg;
        hand_next = hand_reg;
        idx_next = idx_reg;
        step_next = step_reg;
        hit_next = hit_reg;
        hit_frame_next = hit_frame_reg;
        rsp_next = rsp_reg;
        chk_next = 1'b0;
        rd_en = 1'b0;
        rd_addr = '0;
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = cur;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    rd_en = 1'b1;
                    rd_addr = '0;
                    idx_next = (FW+1)'(1);
                    hit_next = 1'b0;
                    chk_next = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                // pipelined scan: issue next read while checking previous
                if (chk_reg && !hit_reg && cur.valid && cur.tag_file == req_reg.file_id
                        && cur.tag_page == req_reg.page_no) begin
                    hit_next = 1'b1;
                    hit_frame_next = rd_addr_reg;
                end
                if (idx_reg < n_act) begin
                    rd_en = 1'b1;
                    rd_addr = idx_reg[FW-1:0];
                    idx_next = idx_reg + 1'b1;
                    chk_next = 1'b1;
                end else begin
                    rd_en = 1'b1;
                    rd_addr = hit_next ? hit_frame_next :
                              ((FW+1)'(hand_reg) >= n_act ? '0 : hand_reg);
                    if (!hit_next && (FW+1)'(hand_reg) >= n_act) hand_next = '0;
                    step_next = '0;
                    state_next = hit_next ? S_DECIDE : S_SWEEP;
                    if (!hit_next && (req_reg.kind == cbfm_pkg::KIND_UNPIN ||
                                      req_reg.kind == cbfm_pkg::KIND_DISPOSE)) begin
                        rsp_next = '0;
                        rsp_next.status = cbfm_pkg::ST_NOT_FOUND;
                        rd_en = 1'b0;
                        state_next = S_OUT;
                    end
                    if (!hit_next && !(req_reg.kind == cbfm_pkg::KIND_UNPIN ||
                                      req_reg.kind == cbfm_pkg::KIND_DISPOSE))
                        state_next = S_SWCHK;
                end
            end
            S_DECIDE: begin
                rsp_next = '0;
                rsp_next.frame = 4'(hit_frame_reg);
                mem_wa = hit_frame_reg;
                state_next = S_OUT;
                unique case (req_reg.kind)
                    cbfm_pkg::KIND_READ, cbfm_pkg::KIND_ALLOC: begin
                        mem_we = 1'b1;
                        mem_wd.referenced = 1'b1;
                        if (cur.pins != cbfm_pkg::PIN_MAX) mem_wd.pins = cur.pins + 1'b1;
                        rsp_next.status = cbfm_pkg::ST_HIT;
                    end
                    cbfm_pkg::KIND_UNPIN: begin
                        if (cur.pins == '0) begin
                            rsp_next.status = cbfm_pkg::ST_NOT_PINNED;
                        end else begin
                            mem_we = 1'b1;
                            mem_wd.pins = cur.pins - 1'b1;
                            if (req_reg.dirty_mark) mem_wd.dirty = 1'b1;
                            rsp_next.status = cbfm_pkg::ST_HIT;
                        end
                    end
                    default: begin
                        mem_we = 1'b1;
                        mem_wd.valid = 1'b0;
                        mem_wd.referenced = 1'b0;
                        mem_wd.dirty = 1'b0;
                        mem_wd.pins = '0;
                        rsp_next.status = cbfm_pkg::ST_HIT;
                    end
                endcase
            end
            S_SWCHK: begin
                // descriptor at hand is in rd_reg
                if (32'(step_reg) >= 2 * 32'(n_act)) begin
                    rsp_next = '0;
                    rsp_next.status = cbfm_pkg::ST_ALL_PINNED;
                    state_next = S_OUT;
                end else if (!cur.valid || (!cur.referenced && cur.pins == '0)) begin
                    rsp_next = '0;
                    rsp_next.status = cbfm_pkg::ST_ASSIGNED;
                    rsp_next.frame = 4'(hand_reg);
                    rsp_next.need_read = (req_reg.kind == cbfm_pkg::KIND_READ);
                    if (cur.valid && cur.dirty) begin
                        rsp_next.write_back = 1'b1;
                        rsp_next.victim_file = cur.tag_file;
                        rsp_next.victim_page = cur.tag_page;
                    end
                    mem_we = 1'b1;
                    mem_wa = hand_reg;
                    mem_wd.valid = 1'b1;
                    mem_wd.referenced = 1'b1;
                    mem_wd.dirty = 1'b0;
                    mem_wd.pins = cbfm_pkg::PIN_BITS'(1);
                    mem_wd.tag_file = req_reg.file_id;
                    mem_wd.tag_page = req_reg.page_no;
                    state_next = S_OUT;
                end else begin
                    if (cur.referenced) begin
                        mem_we = 1'b1;
                        mem_wa = hand_reg;
                        mem_wd.referenced = 1'b0;
                    end
                    hand_next = ((FW+1)'(hand_reg) + 1'b1 >= n_act) ? '0 : hand_reg + 1'b1;
                    step_next = step_reg + 1'b1;
                    state_next = S_SWEEP;
                end
            end
            S_SWEEP: begin
                // wait out the write, then read the new hand position
                rd_en = 1'b1;
                rd_addr = hand_reg;
                state_next = S_SWCHK;
            end
            S_OUT: begin
                if (m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        // a pool size write puts the hand on the last frame in use
        if (cfg_we) begin
            if (cfg_data == 5'd0) hand_next = '0;
            else if (32'(cfg_data) > cbfm_pkg::NUM_FRAMES)
                hand_next = FW'(cbfm_pkg::NUM_FRAMES - 1);
            else hand_next = FW'(cfg_data - 5'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            vbit_reg <= '0;
            fiu_reg <= 5'd16;
            hand_reg <= FW'(cbfm_pkg::NUM_FRAMES - 1);
            chk_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            chk_reg <= chk_next;
            hand_reg <= hand_next;
            if (mem_we) vbit_reg[mem_wa] <= mem_wd.valid;
            if (cfg_we) fiu_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        step_reg <= step_next;
        hit_reg <= hit_next;
        hit_frame_reg <= hit_frame_next;
        rsp_reg <= rsp_next;
        if (s_valid && s_ready) req_reg <= s_data;
    end

endmodule
